/* src/pec_pkg.sv */
// ----------------------------------------------------------------------------
// pec_pkg: shared types and codes of the polynomial easing curve
// Curve kinds, directions, register indexes and the configuration record.
// ----------------------------------------------------------------------------
`default_nettype none

package pec_pkg;

  localparam logic [2:0] KIND_QUAD   = 3'd0;
  localparam logic [2:0] KIND_CUBIC  = 3'd1;
  localparam logic [2:0] KIND_QUART  = 3'd2;
  localparam logic [2:0] KIND_QUINT  = 3'd3;
  localparam logic [2:0] KIND_BACK   = 3'd4;
  localparam logic [2:0] KIND_BOUNCE = 3'd5;

  localparam logic [1:0] DIR_IN    = 2'd0;
  localparam logic [1:0] DIR_OUT   = 2'd1;
  localparam logic [1:0] DIR_INOUT = 2'd2;

  localparam logic [2:0] REG_CURVE_KIND   = 3'd0;
  localparam logic [2:0] REG_DIRECTION    = 3'd1;
  localparam logic [2:0] REG_START_VALUE  = 3'd2;
  localparam logic [2:0] REG_CHANGE_VALUE = 3'd3;
  localparam logic [2:0] REG_DURATION     = 3'd4;

  typedef struct packed {
    logic [2:0]         curve_kind;
    logic [1:0]         direction;
    logic signed [15:0] start_value;
    logic signed [16:0] change_value;
    logic [15:0]        duration;
  } cfg_t;

endpackage

`default_nettype wire

/* src/polynomial_easing_curve.sv */
// ----------------------------------------------------------------------------
// polynomial_easing_curve: fixed-point easing curve generator
// Returns start + change * f(elapsed / duration) for polynomial, back and
// bounce curves, rounded and saturated to 18 bits.
//
//   Channel  Direction  Contents
//   in_      slave      tdata: elapsed
//   out_     master     tdata: eased_value; tuser: finished
//   cfg_     write      curve_kind, direction, start, change, duration
//
// One item per cycle is accepted unless the result is held; the divider
// (one quotient bit per stage) feeds the curve and scaling stages.
// Reset clears the valid bits of all stages; the configuration registers take
// their default values. When the result is held, every stage holds and in_tready
// falls in the same cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module polynomial_easing_curve #(
  parameter int FRAC_BITS = 16
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [15:0] in_tdata,   // [15:0] elapsed
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [23:0]      out_tdata,  // [17:0] eased_value, [23:18] zero
  output logic             out_tuser,  // [0] finished
  input  wire logic        cfg_wr_en,
  input  wire logic [2:0]  cfg_addr,
  input  wire logic [16:0] cfg_wdata
);

  localparam int W  = FRAC_BITS + 4;
  localparam int PR = W + 17;
  localparam int RW = PR - FRAC_BITS;

  pec_pkg::cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.curve_kind   <= pec_pkg::KIND_QUAD;
      cfg_r.direction    <= pec_pkg::DIR_IN;
      cfg_r.start_value  <= '0;
      cfg_r.change_value <= '0;
      cfg_r.duration     <= 16'd1;
    end else if (cfg_wr_en) begin
      unique case (cfg_addr)
        pec_pkg::REG_CURVE_KIND:   cfg_r.curve_kind   <= cfg_wdata[2:0];
        pec_pkg::REG_DIRECTION:    cfg_r.direction    <= cfg_wdata[1:0];
        pec_pkg::REG_START_VALUE:  cfg_r.start_value  <= cfg_wdata[15:0];
        pec_pkg::REG_CHANGE_VALUE: cfg_r.change_value <= cfg_wdata;
        pec_pkg::REG_DURATION:     cfg_r.duration     <= cfg_wdata[15:0];
        default: ;
      endcase
    end
  end

  logic en;
  logic out_valid_r;
  assign en        = !out_valid_r || out_tready;
  assign in_tready = en;

  logic                 dv, dd;
  logic [FRAC_BITS:0]   dp;
  logic                 cv, cd;
  logic signed [W-1:0]  cf;

  pec_div #(.FRAC_BITS(FRAC_BITS)) u_div (
    .clk        (clk),
    .rst_n      (rst_n),
    .en         (en),
    .duration   (cfg_r.duration),
    .in_valid   (in_tvalid),
    .in_elapsed (in_tdata),
    .out_valid  (dv),
    .out_p      (dp),
    .out_done   (dd)
  );

  pec_curve #(.FRAC_BITS(FRAC_BITS)) u_curve (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .cfg       (cfg_r),
    .in_valid  (dv),
    .in_p      (dp),
    .in_done   (dd),
    .out_valid (cv),
    .out_f     (cf),
    .out_done  (cd)
  );

  // Scale by the change, then round, offset and saturate.
  logic                  pv_r, pd_r;
  logic signed [PR-1:0]  prod_r;
  logic [PR-1:0]         pmag, rmag;
  logic signed [RW+1:0]  sum;
  logic signed [17:0]    res_r;
  logic                  fin_r;

  assign pmag = prod_r[PR-1] ? PR'(-prod_r) : PR'(prod_r);
  assign rmag = (pmag + (PR'(1) << (FRAC_BITS - 1))) >> FRAC_BITS;
  assign sum  = (RW+2)'(cfg_r.start_value) +
                (prod_r[PR-1] ? -$signed((RW+2)'(rmag)) : $signed((RW+2)'(rmag)));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pv_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (en) begin
      pv_r        <= cv;
      out_valid_r <= pv_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      prod_r <= cfg_r.change_value * cf;
      pd_r   <= cd;
      fin_r  <= pd_r;
      if (sum > (RW+2)'(131071))       res_r <= 18'sd131071;
      else if (sum < -(RW+2)'(131072)) res_r <= -18'sd131072;
      else                             res_r <= 18'(sum);
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {6'd0, res_r};
  assign out_tuser  = fin_r;

`ifndef SYNTHESIS
  logic signed [18:0] end_sum;
  logic signed [17:0] end_val;
  assign end_sum = 19'(cfg_r.start_value) + 19'(cfg_r.change_value);
  assign end_val = (end_sum > 19'sd131071) ? 18'sd131071 :
                   (end_sum < -19'sd131072) ? -18'sd131072 : 18'(end_sum);

  a_finished_end: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser) |-> (out_tdata[17:0] == end_val))
    else $error("finished item does not sit at the end value");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid right after reset");
`endif

endmodule

`default_nettype wire

/* src/pec_div.sv */
// ----------------------------------------------------------------------------
// pec_div: pipelined normalized-time divider
// Clamps elapsed to the duration and forms floor(elapsed * 2^F / duration),
// one restoring quotient bit per stage.
// ----------------------------------------------------------------------------
`default_nettype none

module pec_div #(
  parameter int FRAC_BITS = 16
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 en,
  input  wire logic [15:0]          duration,
  input  wire logic                 in_valid,
  input  wire logic [15:0]          in_elapsed,
  output logic                      out_valid,
  output logic [FRAC_BITS:0]        out_p,
  output logic                      out_done
);

  logic [15:0]          rem_r  [0:FRAC_BITS];
  logic [FRAC_BITS-1:0] quo_r  [0:FRAC_BITS];
  logic                 vld_r  [0:FRAC_BITS];
  logic                 done_r [0:FRAC_BITS];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k <= FRAC_BITS; k++) vld_r[k] <= 1'b0;
    end else if (en) begin
      vld_r[0] <= in_valid;
      for (int k = 0; k < FRAC_BITS; k++) vld_r[k+1] <= vld_r[k];
    end
  end

  always_ff @(posedge clk) begin
    logic [16:0] trial;
    if (en) begin
      done_r[0] <= (in_elapsed >= duration);
      rem_r[0]  <= in_elapsed;
      quo_r[0]  <= '0;
      for (int k = 0; k < FRAC_BITS; k++) begin
        trial       = {rem_r[k], 1'b0};
        done_r[k+1] <= done_r[k];
        if (trial >= {1'b0, duration}) begin
          rem_r[k+1] <= 16'(trial - {1'b0, duration});
          quo_r[k+1] <= {quo_r[k][FRAC_BITS-2:0], 1'b1};
        end else begin
          rem_r[k+1] <= trial[15:0];
          quo_r[k+1] <= {quo_r[k][FRAC_BITS-2:0], 1'b0};
        end
      end
    end
  end

  // A finished item (this covers a zero duration too) runs at full time.
  assign out_valid = vld_r[FRAC_BITS];
  assign out_done  = done_r[FRAC_BITS];
  assign out_p     = done_r[FRAC_BITS] ? {1'b1, {FRAC_BITS{1'b0}}}
                                       : {1'b0, quo_r[FRAC_BITS]};

`ifndef SYNTHESIS
  a_p_below_one: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_done) |-> !out_p[FRAC_BITS])
    else $error("normalized time reached one for an unfinished item");
`endif

endmodule

`default_nettype wire

/* src/pec_curve.sv */
// ----------------------------------------------------------------------------
// pec_curve: easing curve pipeline
// Maps normalized time to the curve value f in signed fixed point over six
// register stages: fold, square, three further products, direction.
// ----------------------------------------------------------------------------
`default_nettype none

module pec_curve #(
  parameter int FRAC_BITS = 16
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        en,
  input  wire pec_pkg::cfg_t               cfg,
  input  wire logic                        in_valid,
  input  wire logic [FRAC_BITS:0]          in_p,
  input  wire logic                        in_done,
  output logic                             out_valid,
  output logic signed [FRAC_BITS+3:0]      out_f,
  output logic                             out_done
);

  localparam int W  = FRAC_BITS + 4;
  localparam int PW = 2 * W + 8;

  localparam logic signed [W-1:0] ONE = W'(1) << FRAC_BITS;
  localparam logic signed [W-1:0] S1 =
    W'((((longint'(170158) << FRAC_BITS) * 2) + 100000) / 200000);
  localparam logic signed [W-1:0] S2 =
    W'((((longint'(25949095) << FRAC_BITS) * 2) + 10000000) / 20000000);
  localparam logic signed [W-1:0] C6_11  = W'((((longint'(6) << FRAC_BITS) * 2) + 11) / 22);
  localparam logic signed [W-1:0] C9_11  = W'((((longint'(9) << FRAC_BITS) * 2) + 11) / 22);
  localparam logic signed [W-1:0] C21_22 = W'((((longint'(21) << FRAC_BITS) * 2) + 22) / 44);
  localparam logic signed [W-1:0] B3_4   = W'((longint'(3) << FRAC_BITS) / 4);
  localparam logic signed [W-1:0] B15_16 = W'((longint'(15) << FRAC_BITS) / 16);
  localparam logic signed [W-1:0] B63_64 = W'((longint'(63) << FRAC_BITS) / 64);
  localparam logic signed [W+3:0] LIM4  = (W+4)'(4) << FRAC_BITS;
  localparam logic signed [W+3:0] LIM8  = (W+4)'(8) << FRAC_BITS;
  localparam logic signed [W+3:0] LIM10 = (W+4)'(10) << FRAC_BITS;

  // Round away from zero on ties, as a sign-magnitude shift.
  function automatic logic signed [PW-1:0] rnd_sh(input logic signed [PW-1:0] v,
                                                  input int sh);
    logic [PW-1:0] mag;
    mag = v[PW-1] ? PW'(-v) : PW'(v);
    mag = (mag + (PW'(1) << (sh - 1))) >> sh;
    return v[PW-1] ? -$signed(mag) : $signed(mag);
  endfunction

  function automatic logic signed [W-1:0] fmul(input logic signed [W-1:0] a,
                                               input logic signed [W-1:0] b);
    logic signed [2*W-1:0] m;
    m = a * b;
    return W'(rnd_sh(PW'(m), FRAC_BITS));
  endfunction

  logic [2:0] kind;
  assign kind = (cfg.curve_kind > pec_pkg::KIND_BOUNCE) ? pec_pkg::KIND_QUAD
                                                        : cfg.curve_kind;

  logic [5:0] vld_r;
  logic [5:0] done_r;
  logic [4:0] low_r;

  logic signed [W-1:0]   q0_r, q1_r, q2a_r, q1b_r, t1_r, x1_r, base1_r;
  logic signed [W-1:0]   q2_r, q2b_r, q3a_r, bk2_r, base2_r;
  logic signed [2*W-1:0] xx2_r;
  logic signed [W-1:0]   q3_r, q3b_r, q4a_r, back3_r, ob3_r;
  logic signed [W-1:0]   fin4_r, f5_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[4:0], in_valid};
    end
  end

  // Stage 0: fold time for the direction.
  logic signed [W-1:0] pe, p2;
  assign pe = W'(in_p);
  assign p2 = pe <<< 1;

  always_ff @(posedge clk) begin
    if (en) begin
      done_r <= {done_r[4:0], in_done};
      low_r  <= {low_r[3:0], (p2 < ONE)};
      case (cfg.direction)
        pec_pkg::DIR_OUT:   q0_r <= ONE - pe;
        pec_pkg::DIR_INOUT: q0_r <= (p2 < ONE) ? p2 : (ONE <<< 1) - p2;
        default:            q0_r <= pe;
      endcase
    end
  end

  // Stage 1: square, back slope and bounce segment.
  logic signed [W-1:0]   sval, bq;
  logic signed [W+3:0]   b11;
  assign sval = (cfg.direction == pec_pkg::DIR_INOUT) ? S2 : S1;
  assign bq   = ONE - q0_r;
  assign b11  = (W+4)'(bq) * (W+4)'(11);

  always_ff @(posedge clk) begin
    if (en) begin
      q1_r  <= q0_r;
      q2a_r <= fmul(q0_r, q0_r);
      t1_r  <= fmul(sval + ONE, q0_r);
      if (b11 < LIM4) begin
        x1_r <= bq;            base1_r <= '0;
      end else if (b11 < LIM8) begin
        x1_r <= bq - C6_11;    base1_r <= B3_4;
      end else if (b11 < LIM10) begin
        x1_r <= bq - C9_11;    base1_r <= B15_16;
      end else begin
        x1_r <= bq - C21_22;   base1_r <= B63_64;
      end
    end
  end

  // Stage 2
  always_ff @(posedge clk) begin
    if (en) begin
      q1b_r   <= q1_r;
      q2_r    <= q2a_r;
      q3a_r   <= fmul(q2a_r, q1_r);
      bk2_r   <= t1_r - sval;
      xx2_r   <= x1_r * x1_r;
      base2_r <= base1_r;
    end
  end

  // Stage 3
  logic signed [PW-1:0] xx121;
  assign xx121 = PW'(xx2_r) * PW'(121);

  always_ff @(posedge clk) begin
    if (en) begin
      q2b_r   <= q2_r;
      q3_r    <= q3a_r;
      q3b_r   <= q1b_r;
      q4a_r   <= fmul(q3a_r, q1b_r);
      back3_r <= fmul(q2_r, bk2_r);
      ob3_r   <= W'(rnd_sh(xx121, FRAC_BITS + 4)) + base2_r;
    end
  end

  // Stage 4: fifth power and curve select.
  always_ff @(posedge clk) begin
    if (en) begin
      case (kind)
        pec_pkg::KIND_CUBIC:  fin4_r <= q3_r;
        pec_pkg::KIND_QUART:  fin4_r <= q4a_r;
        pec_pkg::KIND_QUINT:  fin4_r <= fmul(q4a_r, q3b_r);
        pec_pkg::KIND_BACK:   fin4_r <= back3_r;
        pec_pkg::KIND_BOUNCE: fin4_r <= ONE - ob3_r;
        default:              fin4_r <= q2b_r;
      endcase
    end
  end

  // Stage 5: unfold for the direction.
  logic signed [W-1:0] half;
  assign half = W'(rnd_sh(PW'(fin4_r), 1));

  always_ff @(posedge clk) begin
    if (en) begin
      case (cfg.direction)
        pec_pkg::DIR_OUT:   f5_r <= ONE - fin4_r;
        pec_pkg::DIR_INOUT: f5_r <= low_r[4] ? half : ONE - half;
        default:            f5_r <= fin4_r;
      endcase
    end
  end

  assign out_valid = vld_r[5];
  assign out_done  = done_r[5];
  assign out_f     = f5_r;

endmodule

`default_nettype wire
